### hdl/pbfl_pkg.sv
package pbfl_pkg;

    localparam int POOL_SLOTS       = 64;
    localparam int MAX_PACKET_BYTES = 2048;

    localparam int SLOT_W   = $clog2(POOL_SLOTS);
    localparam int DEPTH_W  = $clog2(POOL_SLOTS + 1);
    localparam int LEN_W    = 16;
    localparam int HSLOT_W  = 7;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 3;
    localparam int GRANT_W  = 6;
    localparam int FREE_W   = 7;

    localparam int CMD_W      = 1 + LEN_W + 1 + HSLOT_W;
    localparam int RESULT_W   = STATUS_W + GRANT_W + 1 + FREE_W;
    localparam int S_TDATA_W  = ((CMD_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((RESULT_W + 7) / 8) * 8;
    localparam int S_PAD_W    = S_TDATA_W - CMD_W;
    localparam int M_PAD_W    = M_TDATA_W - RESULT_W;

    localparam logic [DEPTH_W-1:0] POOL_DEPTH = DEPTH_W'(POOL_SLOTS);
    localparam logic [HSLOT_W-1:0] POOL_HSLOT = HSLOT_W'(POOL_SLOTS);
    localparam logic [LEN_W-1:0]   MAX_LEN    = LEN_W'(MAX_PACKET_BYTES);

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_FREE    = 2'd1,
        MODE_INIT    = 2'd2,
        MODE_CLEANUP = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 3'd0,
        ST_BAD     = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_OFF     = 3'd3,
        ST_IGNORED = 3'd4
    } t_status;

    // packed msb first, so source_present lands in bit 0
    typedef struct packed {
        logic [HSLOT_W-1:0] handle_slot;
        logic               handle_ok;
        logic [LEN_W-1:0]   packet_length;
        logic               source_present;
    } t_cmd_word;

    typedef struct packed {
        logic [FREE_W-1:0]  slots_free;
        logic               handle_in_pool;
        logic [GRANT_W-1:0] granted_slot;
        t_status            status;
    } t_result;

    typedef struct packed {
        logic capture;
        logic commit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_free;
    } t_ctrl_sts;

endpackage

### hdl/pbfl_ram.sv
module pbfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/pbfl_ctrl.sv
module pbfl_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  pbfl_pkg::t_ctrl_sts i_sts,
    output pbfl_pkg::t_ctrl_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_s_axis_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hdl/pbfl_dp.sv
module pbfl_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pbfl_pkg::t_ctrl_cmd i_cmd,
    output pbfl_pkg::t_ctrl_sts o_sts,
    input  pbfl_pkg::t_mode     i_mode,
    input  pbfl_pkg::t_cmd_word i_word,
    output logic                o_valid,
    input  logic                i_ready,
    output pbfl_pkg::t_result   o_result
);

    pbfl_pkg::t_mode     r_mode;
    pbfl_pkg::t_cmd_word r_word;

    logic [pbfl_pkg::DEPTH_W-1:0]  r_depth, n_depth;
    logic [pbfl_pkg::DEPTH_W-1:0]  r_min, n_min;
    logic                          r_pool_on, n_pool_on;
    logic [pbfl_pkg::POOL_SLOTS-1:0] r_used, n_used;
    logic                          r_out_valid;
    pbfl_pkg::t_result             r_result, n_result;

    logic [pbfl_pkg::DEPTH_W-1:0]  depth_dec;
    logic [pbfl_pkg::SLOT_W-1:0]   ram_q;
    logic [pbfl_pkg::SLOT_W-1:0]   pop_slot;
    logic [pbfl_pkg::SLOT_W-1:0]   hslot;
    logic                          in_pool;
    logic                          bad_req;
    logic                          push_en;

    assign depth_dec = r_depth - 1'b1;
    assign hslot     = r_word.handle_slot[pbfl_pkg::SLOT_W-1:0];
    assign in_pool   = r_word.handle_ok && (r_word.handle_slot < pbfl_pkg::POOL_HSLOT);
    assign bad_req   = !r_word.source_present || (r_word.packet_length == '0)
                       || (r_word.packet_length > pbfl_pkg::MAX_LEN);
    // entries below the low-water mark still hold their refill value
    assign pop_slot  = (depth_dec < r_min) ? depth_dec[pbfl_pkg::SLOT_W-1:0] : ram_q;

    pbfl_ram #(
        .WIDTH (pbfl_pkg::SLOT_W),
        .DEPTH (pbfl_pkg::POOL_SLOTS)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (push_en),
        .i_wr_addr (r_depth[pbfl_pkg::SLOT_W-1:0]),
        .i_wr_data (hslot),
        .i_rd_en   (i_cmd.capture),
        .i_rd_addr (depth_dec[pbfl_pkg::SLOT_W-1:0]),
        .o_rd_data (ram_q)
    );

    always_comb begin
        n_depth   = r_depth;
        n_min     = r_min;
        n_pool_on = r_pool_on;
        n_used    = r_used;
        push_en   = 1'b0;
        n_result  = '0;
        n_result.status = pbfl_pkg::ST_DONE;
        case (r_mode)
            pbfl_pkg::MODE_ALLOC: begin
                if (bad_req) begin
                    n_result.status = pbfl_pkg::ST_BAD;
                end else if (!r_pool_on) begin
                    n_result.status = pbfl_pkg::ST_OFF;
                end else if (r_depth == '0) begin
                    n_result.status = pbfl_pkg::ST_EMPTY;
                end else begin
                    n_depth                = depth_dec;
                    n_min                  = (depth_dec < r_min) ? depth_dec : r_min;
                    n_used[pop_slot]       = 1'b1;
                    n_result.granted_slot  = pop_slot;
                end
            end
            pbfl_pkg::MODE_FREE: begin
                if (!in_pool) begin
                    n_result.status = pbfl_pkg::ST_IGNORED;
                end else if (!r_pool_on) begin
                    n_result.status = pbfl_pkg::ST_OFF;
                end else if (!r_used[hslot]) begin
                    n_result.status = pbfl_pkg::ST_IGNORED;
                end else begin
                    n_used[hslot] = 1'b0;
                    if (r_depth < pbfl_pkg::POOL_DEPTH) begin
                        push_en = i_cmd.commit;
                        n_depth = r_depth + 1'b1;
                    end
                end
            end
            pbfl_pkg::MODE_INIT: begin
                if (!r_pool_on) begin
                    n_used    = '0;
                    n_depth   = pbfl_pkg::POOL_DEPTH;
                    n_min     = pbfl_pkg::POOL_DEPTH;
                    n_pool_on = 1'b1;
                end
            end
            default: begin
                n_used    = '0;
                n_depth   = pbfl_pkg::POOL_DEPTH;
                n_min     = pbfl_pkg::POOL_DEPTH;
                n_pool_on = 1'b0;
            end
        endcase
        n_result.handle_in_pool = in_pool;
        n_result.slots_free     = n_depth;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_word <= i_word;
        end
        if (i_cmd.commit) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= '0;
            r_min       <= '0;
            r_pool_on   <= 1'b0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_depth   <= n_depth;
                r_min     <= n_min;
                r_pool_on <= n_pool_on;
                r_used    <= n_used;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free = !r_out_valid || i_ready;
    assign o_valid        = r_out_valid;
    assign o_result       = r_result;

endmodule

### hdl/packet_buffer_free_list_allocator.sv
// channel   dir  tdata (lsb up)                                          tuser
// s_axis    in   source_present, packet_length, handle_ok, handle_slot   mode
// m_axis    out  status, granted_slot, handle_in_pool, slots_free        -
//
// one command at a time: accept, then the registered stack memory read, then
// the commit of the pool state and the result word
// a result word waits in the output register while the next command is taken
// a stalled output holds the commit, so input stalls after one queued command
// reset is synchronous and needs no clearing pass: the pool is off until init
module packet_buffer_free_list_allocator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // source_present, packet_length, handle_ok, handle_slot, zero pad
    input  logic [pbfl_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // mode
    input  logic [pbfl_pkg::MODE_W-1:0]    i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // status, granted_slot, handle_in_pool, slots_free, zero pad
    output logic [pbfl_pkg::M_TDATA_W-1:0] o_m_axis_tdata
);

    pbfl_pkg::t_ctrl_cmd cmd;
    pbfl_pkg::t_ctrl_sts sts;
    pbfl_pkg::t_cmd_word word;
    pbfl_pkg::t_mode     mode;
    pbfl_pkg::t_result   result;

    assign word = pbfl_pkg::t_cmd_word'(i_s_axis_tdata[pbfl_pkg::CMD_W-1:0]);
    assign mode = pbfl_pkg::t_mode'(i_s_axis_tuser);

    pbfl_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_sts           (sts),
        .o_cmd           (cmd)
    );

    pbfl_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .i_mode   (mode),
        .i_word   (word),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (result)
    );

    assign o_m_axis_tdata = {{pbfl_pkg::M_PAD_W{1'b0}}, result};

endmodule

### hdl/pbfl_checker.sv
module pbfl_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_axis_tvalid,
    input logic                           o_s_axis_tready,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [pbfl_pkg::M_TDATA_W-1:0] o_m_axis_tdata
);

    pbfl_pkg::t_result res;
    assign res = pbfl_pkg::t_result'(o_m_axis_tdata[pbfl_pkg::RESULT_W-1:0]);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result word dropped while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("command taken while previous one in flight");

    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> res.slots_free <= pbfl_pkg::POOL_DEPTH)
        else $error("free depth above pool size");

    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (res.status != pbfl_pkg::ST_DONE) |-> res.granted_slot == '0)
        else $error("slot granted on failed command");

endmodule

bind packet_buffer_free_list_allocator pbfl_checker u_pbfl_checker (.*);
